/* rtl/sfb_pkg.sv */
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types, codes and helpers of the scrolling frame buffer.
// ----------------------------------------------------------------------------
package sfb_pkg;

    // Default sizes of the stores
    localparam int DEF_MAX_WIDTH      = 16;
    localparam int DEF_MAX_HEIGHT     = 16;
    localparam int DEF_MAX_CRATES     = 64;
    localparam int DEF_MAX_CRATE_LEDS = 16;

    // Fixed field widths
    localparam int PIX_W    = 32;
    localparam int CFG_W    = 5;
    localparam int CRD_W    = 4;
    localparam int ACT_W    = 4;
    localparam int CSLOT_W  = 6;
    localparam int LSLOT_W  = 4;
    localparam int ENTRY_W  = 8;
    // Render coordinate: 15 * 31 + 15 fits in 9 bits
    localparam int COORD_W  = 9;
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int REGIDX_W = 3;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE      = 4'd0;
    localparam logic [ACT_W-1:0] ACT_READ       = 4'd1;
    localparam logic [ACT_W-1:0] ACT_FILL       = 4'd2;
    localparam logic [ACT_W-1:0] ACT_PUSH_RIGHT = 4'd3;
    localparam logic [ACT_W-1:0] ACT_PUSH_LEFT  = 4'd4;
    localparam logic [ACT_W-1:0] ACT_PUSH_BOT   = 4'd5;
    localparam logic [ACT_W-1:0] ACT_PUSH_TOP   = 4'd6;
    localparam logic [ACT_W-1:0] ACT_LOAD_CRATE = 4'd7;
    localparam logic [ACT_W-1:0] ACT_LOAD_LED   = 4'd8;
    localparam logic [ACT_W-1:0] ACT_RENDER     = 4'd9;

    // Register indexes (byte address = 4 * index)
    localparam logic [REGIDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [REGIDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [REGIDX_W-1:0] REG_CRATE_COLS   = 3'd2;
    localparam logic [REGIDX_W-1:0] REG_CRATE_ROWS   = 3'd3;
    localparam logic [REGIDX_W-1:0] REG_CRATE_LEDS   = 3'd4;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 5'd16;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 5'd16;
    localparam logic [CFG_W-1:0] RST_CRATE_COLS   = 5'd4;
    localparam logic [CFG_W-1:0] RST_CRATE_ROWS   = 5'd4;
    localparam logic [CFG_W-1:0] RST_CRATE_LEDS   = 5'd16;

    // Clamp a size register to 1..hi
    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v, input int hi);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0)
        begin
            r = CFG_W'(1);
        end
        else if (32'(v) > hi)
        begin
            r = CFG_W'(hi);
        end
        return r;
    endfunction

endpackage

/* rtl/scrolling_frame_buffer_top.sv */
// ----------------------------------------------------------------------------
// scrolling_frame_buffer_top
// Frame store of 32-bit pixels with circular column/row offsets, edge pushes,
// whole-frame fill and LED rendering through crate and in-crate tables.
// ----------------------------------------------------------------------------
// Sequence: loads, unknown actions and out-of-range beats strobe done in the
//   cycle after start; a render that lands outside the frame passes MULX, MULY
//   and CHK; write and push pass REDC, REDR, ADDR and MEM, read adds RDATA,
//   render runs MULX, MULY, CHK and the read path, fill FILLN and SWEEP.
// Throughput: one beat at a time; busy stays high until the beat is done. Beats
//   use the shared compare-subtract modulo unit (one quotient bit per cycle),
//   the shared multiplier and the single pixel memory port.
// Reset: rst_n clears control state, then a clearing pass over all
//   MAX_WIDTH*MAX_HEIGHT entries zeroes the pixel store with busy high;
//   configuration writes are taken during it. The receiver cannot stall done.
// ----------------------------------------------------------------------------
module scrolling_frame_buffer_top
    import sfb_pkg::*;
#(
    parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT     = DEF_MAX_HEIGHT,
    parameter int MAX_CRATES     = DEF_MAX_CRATES,
    parameter int MAX_CRATE_LEDS = DEF_MAX_CRATE_LEDS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // command channel
    input  logic                 start,
    output logic                 busy,
    input  logic [ACT_W-1:0]     action,
    input  logic [CRD_W-1:0]     x,
    input  logic [CRD_W-1:0]     y,
    input  logic [PIX_W-1:0]     value,
    input  logic                 last,
    input  logic [CSLOT_W-1:0]   crate_slot,
    input  logic [LSLOT_W-1:0]   led_slot,
    // result channel
    output logic                 done,
    output logic [PIX_W-1:0]     pixel,
    output logic                 status,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------------
    // Derived sizes
    // ------------------------------------------------------------------------
    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int OW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int OH      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // coordinate (< 32) plus offset (< MAX_DIM) before the modulo
    localparam int RED_W   = $clog2(MAX_DIM + 32);
    localparam int CNT_W   = (RED_W > 1) ? $clog2(RED_W) : 1;
    localparam int MW      = (RED_W > CFG_W) ? RED_W : CFG_W;
    localparam int PW      = 2 * MW + 1;
    localparam int CAW     = (MAX_CRATES > 1) ? $clog2(MAX_CRATES) : 1;
    localparam int LAW     = (MAX_CRATE_LEDS > 1) ? $clog2(MAX_CRATE_LEDS) : 1;
    localparam int CSW     = (CAW > CSLOT_W) ? CAW : CSLOT_W;
    localparam int LSW     = (LAW > LSLOT_W) ? LAW : LSLOT_W;

    // ------------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------------
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_FILLN = 11'b00000000010,  // size the fill through the multiplier
        ST_SWEEP = 11'b00000000100,  // fill or clearing pass, one entry a cycle
        ST_MULX  = 11'b00000001000,  // render column through the multiplier
        ST_MULY  = 11'b00000010000,  // render row through the multiplier
        ST_CHK   = 11'b00000100000,  // render coordinate against the frame
        ST_REDC  = 11'b00001000000,  // column modulo, one step a cycle
        ST_REDR  = 11'b00010000000,  // row modulo, one step a cycle
        ST_ADDR  = 11'b00100000000,  // row * width + column
        ST_MEM   = 11'b01000000000,  // pixel store access
        ST_RDATA = 11'b10000000000   // registered read data out
    } state_t;

    state_t                 state_reg, state_next;

    // configuration
    logic [CFG_W-1:0]       fw_reg, fh_reg, ccols_reg, crows_reg, cleds_reg;
    logic [CFG_W-1:0]       cur_w, cur_h, cur_leds;

    // scroll offsets
    logic [OW-1:0]          co_reg, co_next;
    logic [OH-1:0]          ro_reg, ro_next;

    // beat payload
    logic [ACT_W-1:0]       act_reg, act_next;
    logic                   last_reg, last_next;
    logic [COORD_W-1:0]     cx_reg, cx_next;
    logic [COORD_W-1:0]     cy_reg, cy_next;
    logic [RED_W-1:0]       rem_reg, rem_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [RED_W-1:0]       colmod_reg, colmod_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [PIX_W-1:0]       wdata_reg, wdata_next;

    // sweep engine
    logic [AW:0]            idx_reg, idx_next;
    logic [AW:0]            limit_reg, limit_next;
    logic                   sweep_res_reg, sweep_res_next;

    // result
    logic                   done_reg, done_next;
    logic [PIX_W-1:0]       pixel_reg, pixel_next;
    logic                   status_reg, status_next;

    // memories
    logic [PIX_W-1:0]       pixels_mem [DEPTH];
    logic [ENTRY_W-1:0]     crate_mem [MAX_CRATES];
    logic [ENTRY_W-1:0]     led_mem [MAX_CRATE_LEDS];
    logic [PIX_W-1:0]       rd_data_reg;
    logic [ENTRY_W-1:0]     ce_reg, le_reg;
    logic                   mem_we;
    logic [AW-1:0]          mem_addr;

    // shared units
    logic [MW-1:0]          mul_a, mul_b, mul_add;
    logic [PW-1:0]          prod;
    logic [2*MW-1:0]        red_sub;
    logic                   red_ge;
    logic [RED_W-1:0]       rem_step;
    logic [CFG_W-1:0]       red_mod;

    // command decode
    logic                   accept;
    logic                   cfg_we;
    logic [REGIDX_W-1:0]    reg_idx;
    logic [CSW-1:0]         cslot_ext;
    logic [LSW-1:0]         lslot_ext;
    logic                   cslot_ok, lslot_load_ok, lslot_rend_ok;
    logic                   x_ok, y_ok;
    logic [COORD_W-1:0]     start_cx, start_cy;
    logic                   is_push;

    assign busy    = (state_reg != ST_IDLE);
    assign accept  = start & ~busy;
    assign done    = done_reg;
    assign pixel   = pixel_reg;
    assign status  = status_reg;
    assign pready  = 1'b1;

    assign cur_w    = clamp_dim(fw_reg, MAX_WIDTH);
    assign cur_h    = clamp_dim(fh_reg, MAX_HEIGHT);
    assign cur_leds = clamp_dim(cleds_reg, MAX_CRATE_LEDS);

    assign cslot_ext     = CSW'(crate_slot);
    assign lslot_ext     = LSW'(led_slot);
    assign cslot_ok      = (32'(crate_slot) < MAX_CRATES);
    assign lslot_load_ok = (32'(led_slot) < MAX_CRATE_LEDS);
    assign lslot_rend_ok = (CFG_W'(led_slot) < cur_leds);
    assign x_ok          = (CFG_W'(x) < cur_w);
    assign y_ok          = (CFG_W'(y) < cur_h);

    assign is_push = (act_reg == ACT_PUSH_RIGHT) || (act_reg == ACT_PUSH_LEFT) ||
                     (act_reg == ACT_PUSH_BOT) || (act_reg == ACT_PUSH_TOP);

    // ------------------------------------------------------------------------
    // Configuration port: write on the access cycle; sizes and the LED count read
    // back clamped, crate columns and rows as written
    // ------------------------------------------------------------------------
    assign cfg_we  = psel & penable & pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(cur_w);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(cur_h);
            REG_CRATE_COLS:   prdata = PDATA_W'(ccols_reg);
            REG_CRATE_ROWS:   prdata = PDATA_W'(crows_reg);
            REG_CRATE_LEDS:   prdata = PDATA_W'(cur_leds);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg    <= RST_FRAME_WIDTH;
            fh_reg    <= RST_FRAME_HEIGHT;
            ccols_reg <= RST_CRATE_COLS;
            crows_reg <= RST_CRATE_ROWS;
            cleds_reg <= RST_CRATE_LEDS;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  fw_reg    <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: fh_reg    <= pwdata[CFG_W-1:0];
                REG_CRATE_COLS:   ccols_reg <= pwdata[CFG_W-1:0];
                REG_CRATE_ROWS:   crows_reg <= pwdata[CFG_W-1:0];
                REG_CRATE_LEDS:   cleds_reg <= pwdata[CFG_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Shared multiplier: a * b + add. The sequencer picks the operands.
    // ------------------------------------------------------------------------
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mul_add = '0;
        unique case (state_reg)
            ST_MULX:
            begin
                mul_a   = MW'(ce_reg[3:0]);
                mul_b   = MW'(ccols_reg);
                mul_add = MW'(le_reg[3:0]);
            end
            ST_MULY:
            begin
                mul_a   = MW'(ce_reg[7:4]);
                mul_b   = MW'(crows_reg);
                mul_add = MW'(le_reg[7:4]);
            end
            ST_ADDR:
            begin
                // rem_reg holds the reduced row here
                mul_a   = MW'(rem_reg);
                mul_b   = MW'(cur_w);
                mul_add = MW'(colmod_reg);
            end
            ST_FILLN:
            begin
                mul_a   = MW'(cur_w);
                mul_b   = MW'(cur_h);
            end
            default:
            begin
                mul_a   = '0;
            end
        endcase
    end

    assign prod = (PW'(mul_a) * PW'(mul_b)) + PW'(mul_add);

    // ------------------------------------------------------------------------
    // Shared modulo step: subtract size << cnt where it fits
    // ------------------------------------------------------------------------
    assign red_mod  = (state_reg == ST_REDR) ? cur_h : cur_w;
    assign red_sub  = (2*MW)'(red_mod) << cnt_reg;
    assign red_ge   = ((2*MW)'(rem_reg) >= red_sub);
    assign rem_step = red_ge ? (rem_reg - red_sub[RED_W-1:0]) : rem_reg;

    // ------------------------------------------------------------------------
    // Entry coordinates of the single-pixel actions
    // ------------------------------------------------------------------------
    always_comb
    begin
        start_cx = COORD_W'(x);
        start_cy = COORD_W'(y);
        case (action)
            ACT_PUSH_RIGHT: start_cx = '0;
            ACT_PUSH_LEFT:  start_cx = COORD_W'(cur_w) - 1'b1;
            ACT_PUSH_BOT:   start_cy = '0;
            ACT_PUSH_TOP:   start_cy = COORD_W'(cur_h) - 1'b1;
            default:        start_cx = COORD_W'(x);
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next     = state_reg;
        co_next        = co_reg;
        ro_next        = ro_reg;
        act_next       = act_reg;
        last_next      = last_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        colmod_next    = colmod_reg;
        addr_next      = addr_reg;
        wdata_next     = wdata_reg;
        idx_next       = idx_reg;
        limit_next     = limit_reg;
        sweep_res_next = sweep_res_reg;
        done_next      = 1'b0;
        pixel_next     = '0;
        status_next    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next   = action;
                    last_next  = last;
                    wdata_next = value;
                    cx_next    = start_cx;
                    cy_next    = start_cy;
                    // column modulo starts right away for single-pixel actions
                    rem_next   = RED_W'(start_cx) + RED_W'(co_reg);
                    cnt_next   = CNT_W'(RED_W - 1);
                    unique case (action) inside
                        ACT_WRITE, ACT_READ:
                        begin
                            if (x_ok && y_ok)
                            begin
                                state_next = ST_REDC;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                        end
                        ACT_FILL:
                        begin
                            sweep_res_next = 1'b1;
                            state_next     = ST_FILLN;
                        end
                        ACT_PUSH_RIGHT, ACT_PUSH_LEFT:
                        begin
                            if (y_ok)
                            begin
                                state_next = ST_REDC;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                        end
                        ACT_PUSH_BOT, ACT_PUSH_TOP:
                        begin
                            if (x_ok)
                            begin
                                state_next = ST_REDC;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                        end
                        ACT_LOAD_CRATE:
                        begin
                            done_next   = 1'b1;
                            status_next = ~cslot_ok;
                        end
                        ACT_LOAD_LED:
                        begin
                            done_next   = 1'b1;
                            status_next = ~lslot_load_ok;
                        end
                        ACT_RENDER:
                        begin
                            if (cslot_ok && lslot_rend_ok)
                            begin
                                state_next = ST_MULX;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            status_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_FILLN:
            begin
                limit_next = prod[AW:0];
                idx_next   = '0;
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == limit_reg - 1'b1)
                begin
                    state_next     = ST_IDLE;
                    done_next      = sweep_res_reg;
                    sweep_res_next = 1'b0;
                end
            end
            ST_MULX:
            begin
                cx_next    = prod[COORD_W-1:0];
                state_next = ST_MULY;
            end
            ST_MULY:
            begin
                cy_next    = prod[COORD_W-1:0];
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if ((cx_reg >= COORD_W'(cur_w)) || (cy_reg >= COORD_W'(cur_h)))
                begin
                    done_next   = 1'b1;
                    status_next = 1'b1;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rem_next   = RED_W'(cx_reg) + RED_W'(co_reg);
                    cnt_next   = CNT_W'(RED_W - 1);
                    state_next = ST_REDC;
                end
            end
            ST_REDC:
            begin
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    // column done: hold it, start the row
                    colmod_next = rem_step;
                    rem_next    = RED_W'(cy_reg) + RED_W'(ro_reg);
                    cnt_next    = CNT_W'(RED_W - 1);
                    state_next  = ST_REDR;
                end
            end
            ST_REDR:
            begin
                rem_next = rem_step;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_ADDR;
                end
            end
            ST_ADDR:
            begin
                addr_next  = prod[AW-1:0];
                state_next = ST_MEM;
            end
            ST_MEM:
            begin
                if ((act_reg == ACT_READ) || (act_reg == ACT_RENDER))
                begin
                    state_next = ST_RDATA;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                    // the reduced edge coordinate yields the moved offset
                    if (last_reg)
                    begin
                        case (act_reg)
                            ACT_PUSH_RIGHT:
                            begin
                                if (32'(colmod_reg) + 1 == 32'(cur_w))
                                begin
                                    co_next = '0;
                                end
                                else
                                begin
                                    co_next = OW'(colmod_reg + 1'b1);
                                end
                            end
                            ACT_PUSH_LEFT:
                            begin
                                co_next = OW'(colmod_reg);
                            end
                            ACT_PUSH_BOT:
                            begin
                                if (32'(rem_reg) + 1 == 32'(cur_h))
                                begin
                                    ro_next = '0;
                                end
                                else
                                begin
                                    ro_next = OH'(rem_reg + 1'b1);
                                end
                            end
                            ACT_PUSH_TOP:
                            begin
                                ro_next = OH'(rem_reg);
                            end
                            default:
                            begin
                                co_next = co_reg;
                            end
                        endcase
                    end
                end
            end
            ST_RDATA:
            begin
                done_next  = 1'b1;
                pixel_next = rd_data_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // start with the clearing pass over the whole store
            state_reg     <= ST_SWEEP;
            idx_reg       <= '0;
            limit_reg     <= (AW+1)'(DEPTH);
            wdata_reg     <= '0;
            sweep_res_reg <= 1'b0;
            co_reg        <= '0;
            ro_reg        <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            limit_reg     <= limit_next;
            wdata_reg     <= wdata_next;
            sweep_res_reg <= sweep_res_next;
            co_reg        <= co_next;
            ro_reg        <= ro_next;
            done_reg      <= done_next;
        end
    end

    // beat payload
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        last_reg   <= last_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        colmod_reg <= colmod_next;
        addr_reg   <= addr_next;
        pixel_reg  <= pixel_next;
        status_reg <= status_next;
    end

    // ------------------------------------------------------------------------
    // Pixel store: one write port, one registered read port
    // ------------------------------------------------------------------------
    assign mem_we = (state_reg == ST_SWEEP) ||
                    ((state_reg == ST_MEM) && ((act_reg == ACT_WRITE) || is_push));
    assign mem_addr = (state_reg == ST_SWEEP) ? idx_reg[AW-1:0] : addr_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            pixels_mem[mem_addr] <= wdata_reg;
        end
        rd_data_reg <= pixels_mem[addr_reg];
    end

    // ------------------------------------------------------------------------
    // Crate and in-crate tables: load on accept, read on accept and hold the
    // entries for the render
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_LOAD_CRATE) && cslot_ok)
        begin
            crate_mem[cslot_ext[CAW-1:0]] <= {y, x};
        end
        if (accept)
        begin
            ce_reg <= crate_mem[cslot_ext[CAW-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (action == ACT_LOAD_LED) && lslot_load_ok)
        begin
            led_mem[lslot_ext[LAW-1:0]] <= {y, x};
        end
        if (accept)
        begin
            le_reg <= led_mem[lslot_ext[LAW-1:0]];
        end
    end

endmodule

/* tb/tb_scrolling_frame_buffer_top.sv */
// ----------------------------------------------------------------------------
// tb_scrolling_frame_buffer_top
// Self-checking bench for the scrolling frame buffer. Commands go in over the
// start/busy channel and frame sizes are programmed over APB. An in-bench
// frame model keeps its own pixel store, scroll offsets and LED map tables,
// and predicts every done beat. Directed tests cover each action, the field
// extremes and the range checks. Random phases then run push sequences,
// pixel traffic, table loads and renders under several size settings.
// ----------------------------------------------------------------------------
module tb_scrolling_frame_buffer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sfb_pkg::*;

    localparam int STORE_DEPTH     = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam int RANDOM_PHASES   = 10;
    localparam int BEATS_PER_PHASE = 175;
    // A fill of the full frame is the slowest beat
    localparam int SETTLE_CYCLES   = 300;
    localparam int PRINT_CAP       = 40;
    localparam int RESET_CYCLES    = 11;
    localparam int CRD_MAX         = (1 << CRD_W) - 1;
    // Highest code of the action field; everything above render is unknown
    localparam logic [ACT_W-1:0] ACT_TOP_CODE = '1;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [CRD_W-1:0]   x;
        logic [CRD_W-1:0]   y;
        logic [PIX_W-1:0]   value;
        logic               last;
        logic [CSLOT_W-1:0] crate_slot;
        logic [LSLOT_W-1:0] led_slot;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             status;
    } readout_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic [ACT_W-1:0]   action     = ACT_WRITE;
    logic [CRD_W-1:0]   x          = '0;
    logic [CRD_W-1:0]   y          = '0;
    logic [PIX_W-1:0]   value      = '0;
    logic               last       = 1'b0;
    logic [CSLOT_W-1:0] crate_slot = '0;
    logic [LSLOT_W-1:0] led_slot   = '0;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [PDATA_W-1:0] pwdata     = '0;
    logic               busy;
    logic               done;
    logic [PIX_W-1:0]   pixel;
    logic               status;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    always #1 clk = ~clk;

    scrolling_frame_buffer_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .x          (x),
        .y          (y),
        .value      (value),
        .last       (last),
        .crate_slot (crate_slot),
        .led_slot   (led_slot),
        .done       (done),
        .pixel      (pixel),
        .status     (status),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // ------------------------------------------------------------------
    // Frame model state: pixel store, scroll offsets, LED map tables and
    // the raw size registers as last written
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]   shadow_store [STORE_DEPTH];
    int                 col_shift;
    int                 row_shift;
    logic [ENTRY_W-1:0] crate_map   [DEF_MAX_CRATES];
    logic [ENTRY_W-1:0] led_map     [DEF_MAX_CRATE_LEDS];
    bit                 crate_known [DEF_MAX_CRATES];
    bit                 led_known   [DEF_MAX_CRATE_LEDS];
    logic [CFG_W-1:0]   cfg_regs    [0:int'(REG_CRATE_LEDS)];

    readout_t awaited_readouts[$];
    int       mismatch_count  = 0;
    int       sent_beats      = 0;
    int       sender_idle_pct = 10;

    // Size registers read as 1..hi; zero counts as one
    function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
        if (v == '0)
        begin
            return 1;
        end
        if (int'(v) > hi)
        begin
            return hi;
        end
        return int'(v);
    endfunction

    function automatic int frame_cols();
        return clamp_size(cfg_regs[REG_FRAME_WIDTH], DEF_MAX_WIDTH);
    endfunction

    function automatic int frame_rows();
        return clamp_size(cfg_regs[REG_FRAME_HEIGHT], DEF_MAX_HEIGHT);
    endfunction

    // Offsets are kept raw and reduced by the current size on every use
    function automatic int store_addr(input int cx, input int cy);
        return ((cy + row_shift) % frame_rows()) * frame_cols()
               + ((cx + col_shift) % frame_cols());
    endfunction

    // Apply one accepted beat to the frame model and return its readout
    function automatic readout_t compute_frame_result(input cmd_t c);
        readout_t r;
        int       w;
        int       h;
        int       lim;
        int       px;
        int       py;
        w        = frame_cols();
        h        = frame_rows();
        lim      = clamp_size(cfg_regs[REG_CRATE_LEDS], DEF_MAX_CRATE_LEDS);
        r.pixel  = '0;
        r.status = 1'b0;
        case (c.action)
            ACT_WRITE, ACT_READ:
            begin
                if (c.x >= w || c.y >= h)
                begin
                    r.status = 1'b1;
                end
                else if (c.action == ACT_WRITE)
                begin
                    shadow_store[store_addr(c.x, c.y)] = c.value;
                end
                else
                begin
                    r.pixel = shadow_store[store_addr(c.x, c.y)];
                end
            end
            ACT_FILL:
            begin
                for (int i = 0; i < w * h; i++)
                begin
                    shadow_store[i] = c.value;
                end
            end
            ACT_PUSH_RIGHT, ACT_PUSH_LEFT:
            begin
                if (c.y >= h)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    shadow_store[store_addr((c.action == ACT_PUSH_RIGHT) ? 0 : w - 1,
                                            c.y)] = c.value;
                    if (c.last)
                    begin
                        col_shift = (c.action == ACT_PUSH_RIGHT) ? (col_shift + 1) % w
                                                                 : (col_shift % w + w - 1) % w;
                    end
                end
            end
            ACT_PUSH_BOT, ACT_PUSH_TOP:
            begin
                if (c.x >= w)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    shadow_store[store_addr(c.x,
                                            (c.action == ACT_PUSH_BOT) ? 0 : h - 1)] = c.value;
                    if (c.last)
                    begin
                        row_shift = (c.action == ACT_PUSH_BOT) ? (row_shift + 1) % h
                                                               : (row_shift % h + h - 1) % h;
                    end
                end
            end
            ACT_LOAD_CRATE:
            begin
                if (c.crate_slot >= DEF_MAX_CRATES)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    crate_map[c.crate_slot]   = {c.y, c.x};
                    crate_known[c.crate_slot] = 1'b1;
                end
            end
            ACT_LOAD_LED:
            begin
                if (c.led_slot >= DEF_MAX_CRATE_LEDS)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    led_map[c.led_slot]   = {c.y, c.x};
                    led_known[c.led_slot] = 1'b1;
                end
            end
            ACT_RENDER:
            begin
                if (c.crate_slot >= DEF_MAX_CRATES || c.led_slot >= lim)
                begin
                    r.status = 1'b1;
                end
                else
                begin
                    px = int'(crate_map[c.crate_slot][3:0]) * int'(cfg_regs[REG_CRATE_COLS])
                         + int'(led_map[c.led_slot][3:0]);
                    py = int'(crate_map[c.crate_slot][7:4]) * int'(cfg_regs[REG_CRATE_ROWS])
                         + int'(led_map[c.led_slot][7:4]);
                    if (px >= w || py >= h)
                    begin
                        r.status = 1'b1;
                    end
                    else
                    begin
                        r.pixel = shadow_store[store_addr(px, py)];
                    end
                end
            end
            default:
            begin
                r.status = 1'b1;
            end
        endcase
        if (r.status)
        begin
            r.pixel = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Report, drive and check helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
        begin
            $display("[%0t] mismatch: %s", $realtime, what);
        end
    endtask

    // Every done beat pops the oldest prediction; nothing may arrive unasked
    always @(posedge clk)
    begin : result_check
        readout_t want;
        if (rst_n && done === 1'b1)
        begin
            if (awaited_readouts.size() == 0)
            begin
                report_mismatch("done beat with no command outstanding");
            end
            else
            begin
                want = awaited_readouts.pop_front();
                if (pixel !== want.pixel)
                begin
                    report_mismatch($sformatf("pixel %h, expected %h", pixel, want.pixel));
                end
                if (status !== want.status)
                begin
                    report_mismatch($sformatf("status %b, expected %b", status, want.status));
                end
            end
        end
    end

    function automatic cmd_t make_cmd(
        input logic [ACT_W-1:0]   act,
        input logic [CRD_W-1:0]   cx,
        input logic [CRD_W-1:0]   cy,
        input logic [PIX_W-1:0]   val,
        input logic               lst,
        input logic [CSLOT_W-1:0] cs,
        input logic [LSLOT_W-1:0] ls
    );
        cmd_t c;
        c.action     = act;
        c.x          = cx;
        c.y          = cy;
        c.value      = val;
        c.last       = lst;
        c.crate_slot = cs;
        c.led_slot   = ls;
        return c;
    endfunction

    // Random content in every field; callers override what matters
    function automatic cmd_t scatter_fields();
        cmd_t c;
        c.action     = ACT_W'($urandom());
        c.x          = CRD_W'($urandom());
        c.y          = CRD_W'($urandom());
        c.value      = $urandom();
        c.last       = 1'($urandom());
        c.crate_slot = CSLOT_W'($urandom());
        c.led_slot   = LSLOT_W'($urandom());
        return c;
    endfunction

    function automatic logic [ACT_W-1:0] pick_push_code();
        case ($urandom_range(0, 3))
            0:       return ACT_PUSH_RIGHT;
            1:       return ACT_PUSH_LEFT;
            2:       return ACT_PUSH_BOT;
            default: return ACT_PUSH_TOP;
        endcase
    endfunction

    // Drive one command beat and hold it until the block takes it. Start is
    // left high on return so back-to-back beats need no second assignment.
    task automatic send_cmd(input cmd_t c);
        readout_t r;
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
        end
        start      <= 1'b1;
        action     <= c.action;
        x          <= c.x;
        y          <= c.y;
        value      <= c.value;
        last       <= c.last;
        crate_slot <= c.crate_slot;
        led_slot   <= c.led_slot;
        do @(posedge clk); while (busy !== 1'b0);
        r = compute_frame_result(c);
        sent_beats++;
        awaited_readouts.push_back(r);
    endtask

    // Drop start and hold until every predicted beat is back and busy is low
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge clk); while (awaited_readouts.size() != 0 || busy !== 1'b0);
    endtask

    task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        logic [PDATA_W-1:0] data;
        // Upper data bits are don't-care; scramble them
        data            = $urandom();
        data[CFG_W-1:0] = val;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_regs[idx] = val;
    endtask

    task automatic check_reg(input logic [REGIDX_W-1:0] idx);
        logic [PDATA_W-1:0] want;
        case (idx)
            REG_FRAME_WIDTH:  want = PDATA_W'(frame_cols());
            REG_FRAME_HEIGHT: want = PDATA_W'(frame_rows());
            REG_CRATE_LEDS:   want = PDATA_W'(clamp_size(cfg_regs[idx], DEF_MAX_CRATE_LEDS));
            default:          want = PDATA_W'(cfg_regs[idx]);
        endcase
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
        begin
            report_mismatch($sformatf("register %0d reads %h, expected %h", idx, prdata, want));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Reprogram all sizes while idle, then read every register back
    task automatic set_frame(
        input logic [CFG_W-1:0] w_raw,
        input logic [CFG_W-1:0] h_raw,
        input logic [CFG_W-1:0] cc_raw,
        input logic [CFG_W-1:0] cr_raw,
        input logic [CFG_W-1:0] leds_raw
    );
        drain_results();
        write_reg(REG_FRAME_WIDTH,  w_raw);
        write_reg(REG_FRAME_HEIGHT, h_raw);
        write_reg(REG_CRATE_COLS,   cc_raw);
        write_reg(REG_CRATE_ROWS,   cr_raw);
        write_reg(REG_CRATE_LEDS,   leds_raw);
        for (int i = 0; i <= int'(REG_CRATE_LEDS); i++)
        begin
            check_reg(REGIDX_W'(i));
        end
    endtask

    // One column or row pushed element by element; the final element carries
    // last. A broken run stops early, may stray out of range or mark last
    // on a middle element.
    task automatic push_run();
        cmd_t             c;
        logic [ACT_W-1:0] dir;
        int               len;
        int               cut;
        int               idx;
        bit               broken;
        bit               by_column;
        dir       = pick_push_code();
        by_column = (dir == ACT_PUSH_RIGHT || dir == ACT_PUSH_LEFT);
        len       = by_column ? frame_rows() : frame_cols();
        broken    = ($urandom_range(0, 4) == 0);
        cut       = broken ? $urandom_range(0, len - 1) : len - 1;
        for (int i = 0; i <= cut; i++)
        begin
            c        = scatter_fields();
            c.action = dir;
            idx      = (broken && $urandom_range(0, 3) == 0) ? $urandom_range(0, CRD_MAX) : i;
            if (by_column)
            begin
                c.y = CRD_W'(idx);
            end
            else
            begin
                c.x = CRD_W'(idx);
            end
            c.last = (i == cut) || (broken && $urandom_range(0, 7) == 0);
            send_cmd(c);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Wait out the clearing pass, check reset values and a cleared pixel
    task automatic test_reset_state();
        drain_results();
        for (int i = 0; i <= int'(REG_CRATE_LEDS); i++)
        begin
            check_reg(REGIDX_W'(i));
        end
        send_cmd(make_cmd(ACT_READ, CRD_MAX, CRD_MAX, '0, 1'b0, '0, '0));
    endtask

    // Corner writes and reads, a fill, and one push of each kind with last
    task automatic test_pixel_ops();
        send_cmd(make_cmd(ACT_WRITE, CRD_MAX, CRD_MAX, '1, 1'b0, '1, '1));
        send_cmd(make_cmd(ACT_WRITE, 0, 0, 32'h8000_0001, 1'b1, '0, '0));
        send_cmd(make_cmd(ACT_READ, CRD_MAX, CRD_MAX, '0, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_READ, 0, 0, '1, 1'b1, '1, '1));
        send_cmd(make_cmd(ACT_FILL, 0, 0, 32'h5AA5_C33C, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_READ, 7, 9, '0, 1'b0, '0, '0));
        // Each push moves its offset; the pairs cancel out again
        send_cmd(make_cmd(ACT_PUSH_RIGHT, 0, CRD_MAX, 32'h0000_00FF, 1'b1, '0, '0));
        send_cmd(make_cmd(ACT_PUSH_LEFT, 0, 0, 32'h0000_FF00, 1'b1, '0, '0));
        send_cmd(make_cmd(ACT_PUSH_BOT, CRD_MAX, 0, 32'h00FF_0000, 1'b1, '0, '0));
        send_cmd(make_cmd(ACT_PUSH_TOP, 0, 0, 32'hFF00_0000, 1'b1, '0, '0));
    endtask

    // Table loads at both ends, renders inside and outside the frame, and
    // an unknown action with every field bit set
    task automatic test_led_map();
        send_cmd(make_cmd(ACT_LOAD_CRATE, CRD_MAX, CRD_MAX, '0, 1'b0, '1, '0));
        send_cmd(make_cmd(ACT_LOAD_CRATE, 1, 2, '0, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_LOAD_LED, CRD_MAX, CRD_MAX, '0, 1'b0, '0, '1));
        send_cmd(make_cmd(ACT_LOAD_LED, 3, 1, '0, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_RENDER, 0, 0, '0, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_RENDER, 0, 0, '0, 1'b0, '1, '1));
        send_cmd(make_cmd(ACT_TOP_CODE, CRD_MAX, CRD_MAX, '1, 1'b1, '1, '1));
    endtask

    // Small frame: coordinates past the edge, pushes with last that must not
    // scroll, and renders past the in-crate length or outside the frame
    task automatic test_range_checks();
        set_frame(5, 3, 0, 4, 0);
        send_cmd(make_cmd(ACT_WRITE, CRD_MAX, 0, '1, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_READ, 0, CRD_MAX, '0, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_PUSH_RIGHT, 0, CRD_MAX, '1, 1'b1, '0, '0));
        send_cmd(make_cmd(ACT_PUSH_TOP, CRD_MAX, 0, '1, 1'b1, '0, '0));
        send_cmd(make_cmd(ACT_RENDER, 0, 0, '0, 1'b0, '0, 1));
        send_cmd(make_cmd(ACT_RENDER, 0, 0, '0, 1'b0, '0, '0));
        send_cmd(make_cmd(ACT_READ, 4, 2, '0, 1'b0, '0, '0));
    endtask

    // Random phases, each under its own sizes; offsets carry over between
    // phases so they are reduced against changed sizes
    task automatic test_random_traffic();
        cmd_t c;
        int   w;
        int   h;
        int   lim;
        int   pick;
        int   phase_goal;
        int   slot;
        bit   led_ok;
        bit   crate_ok;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       set_frame(RST_FRAME_WIDTH, RST_FRAME_HEIGHT, RST_CRATE_COLS,
                                   RST_CRATE_ROWS, RST_CRATE_LEDS);
                1:       set_frame('0, '0, '0, '0, '0);
                2:       set_frame('1, '1, '1, '1, '1);
                default: set_frame(CFG_W'($urandom_range(0, 31)), CFG_W'($urandom_range(0, 31)),
                                   CFG_W'($urandom_range(0, 5)), CFG_W'($urandom_range(0, 5)),
                                   CFG_W'($urandom_range(0, 31)));
            endcase
            // First phase runs back to back with no idling at all
            sender_idle_pct = (p == 0) ? 0 : 10;
            phase_goal      = sent_beats + BEATS_PER_PHASE;
            while (sent_beats < phase_goal)
            begin
                w    = frame_cols();
                h    = frame_rows();
                lim  = clamp_size(cfg_regs[REG_CRATE_LEDS], DEF_MAX_CRATE_LEDS);
                c    = scatter_fields();
                pick = $urandom_range(0, 99);
                if (pick == 0)
                begin
                    // Hold off the sender until the block has fully drained
                    drain_results();
                    continue;
                end
                else if (pick < 33)
                begin
                    c.action = (pick < 15) ? ACT_WRITE : ACT_READ;
                    if ($urandom_range(0, 9) != 0)
                    begin
                        c.x = CRD_W'($urandom_range(0, w - 1));
                        c.y = CRD_W'($urandom_range(0, h - 1));
                    end
                end
                else if (pick < 36)
                begin
                    c.action = ACT_FILL;
                end
                else if (pick < 56)
                begin
                    push_run();
                    continue;
                end
                else if (pick < 61)
                begin
                    c.action = pick_push_code();
                end
                else if (pick < 74)
                begin
                    // Mostly small entries so renders land inside the frame
                    c.action = (pick < 69) ? ACT_LOAD_CRATE : ACT_LOAD_LED;
                    if ($urandom_range(0, 9) < 7)
                    begin
                        c.x = CRD_W'($urandom_range(0, 3));
                        c.y = CRD_W'($urandom_range(0, 3));
                    end
                end
                else if (pick < 97)
                begin
                    c.action = ACT_RENDER;
                    if (lim < DEF_MAX_CRATE_LEDS && $urandom_range(0, 6) == 0)
                    begin
                        c.led_slot = LSLOT_W'($urandom_range(lim, DEF_MAX_CRATE_LEDS - 1));
                    end
                    else
                    begin
                        // Steer onto loaded table entries; never read an empty one
                        c.led_slot = LSLOT_W'($urandom_range(0, lim - 1));
                        led_ok     = 1'b0;
                        crate_ok   = 1'b0;
                        for (int k = 0; k < lim && !led_ok; k++)
                        begin
                            slot = (int'(c.led_slot) + k) % lim;
                            if (led_known[slot])
                            begin
                                c.led_slot = LSLOT_W'(slot);
                                led_ok     = 1'b1;
                            end
                        end
                        for (int k = 0; k < DEF_MAX_CRATES && !crate_ok; k++)
                        begin
                            slot = (int'(c.crate_slot) + k) % DEF_MAX_CRATES;
                            if (crate_known[slot])
                            begin
                                c.crate_slot = CSLOT_W'(slot);
                                crate_ok     = 1'b1;
                            end
                        end
                        if (!led_ok)
                        begin
                            c.action = ACT_LOAD_LED;
                        end
                        else if (!crate_ok)
                        begin
                            c.action = ACT_LOAD_CRATE;
                        end
                    end
                end
                else
                begin
                    c.action = ACT_W'($urandom_range(int'(ACT_RENDER) + 1, int'(ACT_TOP_CODE)));
                end
                send_cmd(c);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence: reset once, run the tests in turn, drain, then settle long
    // enough for any stray done beat to show up
    // ------------------------------------------------------------------
    initial
    begin
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            shadow_store[i] = '0;
        end
        for (int i = 0; i < DEF_MAX_CRATES; i++)
        begin
            crate_map[i]   = '0;
            crate_known[i] = 1'b0;
        end
        for (int i = 0; i < DEF_MAX_CRATE_LEDS; i++)
        begin
            led_map[i]   = '0;
            led_known[i] = 1'b0;
        end
        col_shift                  = 0;
        row_shift                  = 0;
        cfg_regs[REG_FRAME_WIDTH]  = RST_FRAME_WIDTH;
        cfg_regs[REG_FRAME_HEIGHT] = RST_FRAME_HEIGHT;
        cfg_regs[REG_CRATE_COLS]   = RST_CRATE_COLS;
        cfg_regs[REG_CRATE_ROWS]   = RST_CRATE_ROWS;
        cfg_regs[REG_CRATE_LEDS]   = RST_CRATE_LEDS;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_pixel_ops();
        test_led_map();
        test_range_checks();
        test_random_traffic();

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("tb_scrolling_frame_buffer_top passed");
        end
        else
        begin
            $display("tb_scrolling_frame_buffer_top failed");
        end
        $finish;
    end

    // Watchdog: far beyond a run where every beat is a full-frame fill
    initial
    begin
        #5_000_000;
        $display("tb_scrolling_frame_buffer_top failed");
        $finish;
    end

endmodule
